@@ src/msc_pkg.sv @@
package msc_pkg;

  localparam int MSC_MEM_BYTES = 65536;

  localparam logic [15:0] MSC_START_RESET = 16'd512;
  localparam logic [15:0] MSC_CON_DATA    = 16'o177566;
  localparam logic [15:0] MSC_CON_STATUS  = 16'o177564;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_EXEC    = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_HALT   = 3'd1;
  localparam logic [2:0] ST_OPCODE = 3'd2;
  localparam logic [2:0] ST_MODE   = 3'd3;
  localparam logic [2:0] ST_ODD    = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
    logic [2:0]  reg_index;
  } msc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] read_value;
    logic [15:0] pc_now;
    logic        console_valid;
    logic [7:0]  console_char;
    logic        flag_n;
    logic        flag_z;
  } msc_out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } msc_eng_stat_t;

endpackage

@@ src/msc_engine.sv @@
module msc_engine
  import msc_pkg::*;
#(
  parameter int MEM_BYTES = MSC_MEM_BYTES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  msc_in_t       cmd_in,
  input  logic [15:0]   start_address,
  input  logic          take,
  output msc_eng_stat_t stat,
  output msc_out_t      res
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] CS_IDX = MSC_CON_STATUS[AW-1:0];

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLEAR = 5'd1;
  localparam logic [4:0] S_F0    = 5'd2;
  localparam logic [4:0] S_F1    = 5'd3;
  localparam logic [4:0] S_F2    = 5'd4;
  localparam logic [4:0] S_DEC   = 5'd5;
  localparam logic [4:0] S_RES0  = 5'd6;
  localparam logic [4:0] S_RESLO = 5'd7;
  localparam logic [4:0] S_RESHI = 5'd8;
  localparam logic [4:0] S_GET0  = 5'd9;
  localparam logic [4:0] S_GET1  = 5'd10;
  localparam logic [4:0] S_GET2  = 5'd11;
  localparam logic [4:0] S_USE   = 5'd12;
  localparam logic [4:0] S_PUT1  = 5'd13;
  localparam logic [4:0] S_SOB0  = 5'd14;
  localparam logic [4:0] S_SOB1  = 5'd15;
  localparam logic [4:0] S_J0    = 5'd16;
  localparam logic [4:0] S_J1    = 5'd17;
  localparam logic [4:0] S_J2    = 5'd18;
  localparam logic [4:0] S_J3    = 5'd19;
  localparam logic [4:0] S_J4    = 5'd20;
  localparam logic [4:0] S_J5    = 5'd21;
  localparam logic [4:0] S_R0    = 5'd22;
  localparam logic [4:0] S_R1    = 5'd23;
  localparam logic [4:0] S_R2    = 5'd24;
  localparam logic [4:0] S_R3    = 5'd25;
  localparam logic [4:0] S_R4    = 5'd26;
  localparam logic [4:0] S_RST0  = 5'd27;
  localparam logic [4:0] S_RST1  = 5'd28;
  localparam logic [4:0] S_DONE  = 5'd29;

  localparam logic [3:0] C_MOV  = 4'd0;
  localparam logic [3:0] C_ADD  = 4'd1;
  localparam logic [3:0] C_MOVB = 4'd2;
  localparam logic [3:0] C_CLR  = 4'd3;
  localparam logic [3:0] C_DECR = 4'd4;
  localparam logic [3:0] C_TST  = 4'd5;
  localparam logic [3:0] C_TSTB = 4'd6;
  localparam logic [3:0] C_JSR  = 4'd7;
  localparam logic [3:0] C_MUL  = 4'd8;

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata_r;
  logic        mem_we;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wdata;

  logic [15:0] regs_r  [8];
  logic [15:0] saved_r [8];
  logic        reg_we;
  logic [2:0]  reg_widx;
  logic [15:0] reg_wdata;
  logic [2:0]  rd_idx;
  logic [15:0] reg_rd;
  logic        restore;
  logic        snap;

  logic [4:0]    state_r, state_nxt;
  logic [15:0]   ir_r, ir_nxt;
  logic [3:0]    cls_r, cls_nxt;
  logic          phase_r, phase_nxt;
  logic          isreg_r, isreg_nxt;
  logic [15:0]   ea_r, ea_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic [15:0]   val_r, val_nxt;
  logic [15:0]   src_r, src_nxt;
  logic [15:0]   ptr_r, ptr_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [15:0]   readv_r, readv_nxt;
  logic          conv_r, conv_nxt;
  logic [7:0]    conc_r, conc_nxt;
  logic          halted_r, halted_nxt;
  logic          fn_r, fn_nxt;
  logic          fz_r, fz_nxt;
  logic          sfn_r, sfz_r;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [2:0]  res_mode, res_rn;
  logic        byte_op, word_acc;
  logic [15:0] step;
  logic [4:0]  cont_state;
  logic        ea_set;
  logic [15:0] ea_val;
  logic        fault_req;
  logic [2:0]  fault_code;
  logic [15:0] wv;
  logic        put_req;
  logic [15:0] prod;
  logic [15:0] t16;
  logic        br_take;

  assign res_mode = phase_r ? ir_r[5:3] : ir_r[11:9];
  assign res_rn   = phase_r ? ir_r[2:0] : ir_r[8:6];
  assign byte_op  = (cls_r == C_MOVB) || (cls_r == C_TSTB);
  assign word_acc = (cls_r == C_MOV) || (cls_r == C_ADD) || (cls_r == C_CLR) ||
                    (cls_r == C_DECR) || (cls_r == C_TST) || (cls_r == C_MUL);
  assign step     = (byte_op && (res_rn < 3'd6)) ? 16'd1 : 16'd2;
  assign reg_rd   = regs_r[rd_idx];
  // keep the low half of the product only
  assign prod     = reg_rd * val_r;

  always_comb begin
    if (!phase_r) begin
      cont_state = S_GET0;
    end else begin
      case (cls_r)
        C_ADD, C_DECR, C_TST, C_TSTB, C_MUL: cont_state = S_GET0;
        C_JSR:                               cont_state = S_J0;
        default:                             cont_state = S_USE;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ir_nxt     = ir_r;
    cls_nxt    = cls_r;
    phase_nxt  = phase_r;
    isreg_nxt  = isreg_r;
    ea_nxt     = ea_r;
    lo_nxt     = lo_r;
    val_nxt    = val_r;
    src_nxt    = src_r;
    ptr_nxt    = ptr_r;
    status_nxt = status_r;
    readv_nxt  = readv_r;
    conv_nxt   = conv_r;
    conc_nxt   = conc_r;
    halted_nxt = halted_r;
    fn_nxt     = fn_r;
    fz_nxt     = fz_r;
    clr_nxt    = clr_r;
    reg_we     = 1'b0;
    reg_widx   = 3'd7;
    reg_wdata  = '0;
    rd_idx     = res_rn;
    restore    = 1'b0;
    snap       = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = ea_r;
    mem_wdata  = '0;
    ea_set     = 1'b0;
    ea_val     = '0;
    fault_req  = 1'b0;
    fault_code = ST_OK;
    wv         = '0;
    put_req    = 1'b0;
    t16        = '0;
    br_take    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = 16'(clr_r);
        mem_wdata = (clr_r == CS_IDX) ? 8'hFF : 8'h00;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_idx = cmd_in.reg_index;
        if (start) begin
          status_nxt = ST_OK;
          readv_nxt  = '0;
          conv_nxt   = 1'b0;
          conc_nxt   = '0;
          state_nxt  = S_DONE;
          unique case (cmd_in.cmd)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              mem_addr  = cmd_in.address;
              mem_wdata = cmd_in.data;
            end
            CMD_EXEC: begin
              if (halted_r) begin
                status_nxt = ST_HALT;
              end else begin
                snap      = 1'b1;
                state_nxt = S_F0;
              end
            end
            CMD_READ: begin
              readv_nxt = reg_rd;
            end
            CMD_RESTART: begin
              reg_we     = 1'b1;
              reg_widx   = 3'd7;
              reg_wdata  = start_address;
              halted_nxt = 1'b0;
              state_nxt  = S_RST0;
            end
            default: ;
          endcase
        end
      end
      S_F0: begin
        if (regs_r[7][0]) begin
          fault_req  = 1'b1;
          fault_code = ST_ODD;
        end else begin
          mem_addr  = regs_r[7];
          state_nxt = S_F1;
        end
      end
      S_F1: begin
        lo_nxt    = rdata_r;
        mem_addr  = regs_r[7] + 16'd1;
        state_nxt = S_F2;
      end
      S_F2: begin
        ir_nxt    = {rdata_r, lo_r};
        reg_we    = 1'b1;
        reg_widx  = 3'd7;
        reg_wdata = regs_r[7] + 16'd2;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_RES0;
        phase_nxt = 1'b1;
        if (ir_r == 16'd0) begin
          halted_nxt = 1'b1;
          status_nxt = ST_HALT;
          state_nxt  = S_DONE;
        end else if ((ir_r & 16'o170000) == 16'o010000) begin
          cls_nxt   = C_MOV;
          phase_nxt = 1'b0;
        end else if ((ir_r & 16'o170000) == 16'o060000) begin
          cls_nxt   = C_ADD;
          phase_nxt = 1'b0;
        end else if ((ir_r & 16'o170000) == 16'o110000) begin
          cls_nxt   = C_MOVB;
          phase_nxt = 1'b0;
        end else if ((ir_r & 16'o177000) == 16'o077000) begin
          state_nxt = S_SOB0;
        end else if ((ir_r & 16'hFF00) == 16'o000400 || (ir_r & 16'hFF00) == 16'o001400 ||
                     (ir_r & 16'hFF00) == 16'o100000) begin
          if ((ir_r & 16'hFF00) == 16'o001400) begin
            br_take = fz_r;
          end else if ((ir_r & 16'hFF00) == 16'o100000) begin
            br_take = !fn_r;
          end else begin
            br_take = 1'b1;
          end
          if (br_take) begin
            reg_we    = 1'b1;
            reg_widx  = 3'd7;
            reg_wdata = regs_r[7] + {{7{ir_r[7]}}, ir_r[7:0], 1'b0};
          end
          state_nxt = S_DONE;
        end else if ((ir_r & 16'o177700) == 16'o005000) begin
          cls_nxt = C_CLR;
        end else if ((ir_r & 16'o177700) == 16'o005300) begin
          cls_nxt = C_DECR;
        end else if ((ir_r & 16'o177700) == 16'o005700) begin
          cls_nxt = C_TST;
        end else if ((ir_r & 16'o177700) == 16'o105700) begin
          cls_nxt = C_TSTB;
        end else if ((ir_r & 16'o177000) == 16'o004000) begin
          cls_nxt = C_JSR;
          if (ir_r[5:3] == 3'd0) begin
            fault_req  = 1'b1;
            fault_code = ST_MODE;
          end
        end else if ((ir_r & 16'o177770) == 16'o000200) begin
          state_nxt = S_R0;
        end else if ((ir_r & 16'o177000) == 16'o070000) begin
          cls_nxt = C_MUL;
        end else begin
          fault_req  = 1'b1;
          fault_code = ST_OPCODE;
        end
      end
      S_SOB0: begin
        rd_idx    = ir_r[8:6];
        reg_we    = 1'b1;
        reg_widx  = ir_r[8:6];
        reg_wdata = reg_rd - 16'd1;
        state_nxt = S_SOB1;
      end
      S_SOB1: begin
        rd_idx = ir_r[8:6];
        if (reg_rd != 16'd0) begin
          reg_we    = 1'b1;
          reg_widx  = 3'd7;
          reg_wdata = regs_r[7] - {9'd0, ir_r[5:0], 1'b0};
        end
        state_nxt = S_DONE;
      end
      S_RES0: begin
        rd_idx = res_rn;
        case (res_mode)
          3'd0: begin
            isreg_nxt = 1'b1;
            ea_nxt    = {13'd0, res_rn};
            state_nxt = cont_state;
          end
          3'd1: begin
            ea_set = 1'b1;
            ea_val = reg_rd;
          end
          3'd2: begin
            ea_set    = 1'b1;
            ea_val    = reg_rd;
            reg_we    = 1'b1;
            reg_widx  = res_rn;
            reg_wdata = reg_rd + step;
          end
          3'd3: begin
            if (reg_rd[0]) begin
              fault_req  = 1'b1;
              fault_code = ST_ODD;
            end else begin
              ptr_nxt   = reg_rd;
              reg_we    = 1'b1;
              reg_widx  = res_rn;
              reg_wdata = reg_rd + 16'd2;
              mem_addr  = reg_rd;
              state_nxt = S_RESLO;
            end
          end
          3'd4: begin
            t16       = reg_rd - step;
            ea_set    = 1'b1;
            ea_val    = t16;
            reg_we    = 1'b1;
            reg_widx  = res_rn;
            reg_wdata = t16;
          end
          3'd5: begin
            t16 = reg_rd - 16'd2;
            if (t16[0]) begin
              fault_req  = 1'b1;
              fault_code = ST_ODD;
            end else begin
              ptr_nxt   = t16;
              reg_we    = 1'b1;
              reg_widx  = res_rn;
              reg_wdata = t16;
              mem_addr  = t16;
              state_nxt = S_RESLO;
            end
          end
          3'd6: begin
            if (regs_r[7][0]) begin
              fault_req  = 1'b1;
              fault_code = ST_ODD;
            end else begin
              ptr_nxt   = regs_r[7];
              reg_we    = 1'b1;
              reg_widx  = 3'd7;
              reg_wdata = regs_r[7] + 16'd2;
              mem_addr  = regs_r[7];
              state_nxt = S_RESLO;
            end
          end
          default: begin
            fault_req  = 1'b1;
            fault_code = ST_MODE;
          end
        endcase
      end
      S_RESLO: begin
        lo_nxt    = rdata_r;
        mem_addr  = ptr_r + 16'd1;
        state_nxt = S_RESHI;
      end
      S_RESHI: begin
        // index mode adds the register after the pc has stepped past the offset
        rd_idx = res_rn;
        ea_set = 1'b1;
        if (res_mode == 3'd6) begin
          ea_val = {rdata_r, lo_r} + reg_rd;
        end else begin
          ea_val = {rdata_r, lo_r};
        end
      end
      S_GET0: begin
        rd_idx = ea_r[2:0];
        if (isreg_r) begin
          val_nxt   = byte_op ? {8'd0, reg_rd[7:0]} : reg_rd;
          state_nxt = S_USE;
        end else begin
          mem_addr  = ea_r;
          state_nxt = S_GET1;
        end
      end
      S_GET1: begin
        if (byte_op) begin
          val_nxt   = {8'd0, rdata_r};
          state_nxt = S_USE;
        end else begin
          lo_nxt    = rdata_r;
          mem_addr  = ea_r + 16'd1;
          state_nxt = S_GET2;
        end
      end
      S_GET2: begin
        val_nxt   = {rdata_r, lo_r};
        state_nxt = S_USE;
      end
      S_USE: begin
        state_nxt = S_DONE;
        if (!phase_r) begin
          src_nxt   = val_r;
          phase_nxt = 1'b1;
          state_nxt = S_RES0;
        end else begin
          case (cls_r)
            C_MOV: begin
              wv      = src_r;
              put_req = 1'b1;
            end
            C_ADD: begin
              wv      = src_r + val_r;
              put_req = 1'b1;
            end
            C_DECR: begin
              wv      = val_r - 16'd1;
              put_req = 1'b1;
            end
            C_CLR: begin
              put_req = 1'b1;
            end
            C_TST: begin
              fn_nxt = val_r[15];
              fz_nxt = (val_r == 16'd0);
            end
            C_TSTB: begin
              fn_nxt = val_r[7];
              fz_nxt = (val_r[7:0] == 8'd0);
            end
            C_MUL: begin
              rd_idx    = ir_r[8:6];
              reg_we    = 1'b1;
              reg_widx  = ir_r[8:6];
              reg_wdata = prod;
            end
            C_MOVB: begin
              fn_nxt = src_r[7];
              fz_nxt = (src_r[7:0] == 8'd0);
              if (isreg_r) begin
                reg_we    = 1'b1;
                reg_widx  = ea_r[2:0];
                reg_wdata = {{8{src_r[7]}}, src_r[7:0]};
              end else begin
                mem_we    = 1'b1;
                mem_addr  = ea_r;
                mem_wdata = src_r[7:0];
                if (ea_r == MSC_CON_DATA) begin
                  conv_nxt = 1'b1;
                  conc_nxt = src_r[7:0];
                end
              end
            end
            default: ;
          endcase
          if (put_req) begin
            if (cls_r == C_CLR) begin
              fn_nxt = 1'b0;
              fz_nxt = 1'b1;
            end else begin
              fn_nxt = wv[15];
              fz_nxt = (wv == 16'd0);
            end
            if (isreg_r) begin
              reg_we    = 1'b1;
              reg_widx  = ea_r[2:0];
              reg_wdata = wv;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = ea_r;
              mem_wdata = wv[7:0];
              val_nxt   = wv;
              state_nxt = S_PUT1;
            end
          end
        end
      end
      S_PUT1: begin
        mem_we    = 1'b1;
        mem_addr  = ea_r + 16'd1;
        mem_wdata = val_r[15:8];
        state_nxt = S_DONE;
      end
      S_J0: begin
        t16 = regs_r[6] - 16'd2;
        if (t16[0]) begin
          fault_req  = 1'b1;
          fault_code = ST_ODD;
        end else begin
          ptr_nxt   = t16;
          state_nxt = S_J1;
        end
      end
      S_J1: begin
        // capture the linkage register before the stack pointer moves
        rd_idx    = ir_r[8:6];
        val_nxt   = reg_rd;
        reg_we    = 1'b1;
        reg_widx  = 3'd6;
        reg_wdata = ptr_r;
        state_nxt = S_J2;
      end
      S_J2: begin
        mem_we    = 1'b1;
        mem_addr  = ptr_r;
        mem_wdata = val_r[7:0];
        state_nxt = S_J3;
      end
      S_J3: begin
        mem_we    = 1'b1;
        mem_addr  = ptr_r + 16'd1;
        mem_wdata = val_r[15:8];
        state_nxt = S_J4;
      end
      S_J4: begin
        reg_we    = 1'b1;
        reg_widx  = ir_r[8:6];
        reg_wdata = regs_r[7];
        state_nxt = S_J5;
      end
      S_J5: begin
        reg_we    = 1'b1;
        reg_widx  = 3'd7;
        reg_wdata = ea_r;
        state_nxt = S_DONE;
      end
      S_R0: begin
        if (regs_r[6][0]) begin
          fault_req  = 1'b1;
          fault_code = ST_ODD;
        end else begin
          ptr_nxt   = regs_r[6];
          mem_addr  = regs_r[6];
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        lo_nxt    = rdata_r;
        mem_addr  = ptr_r + 16'd1;
        state_nxt = S_R2;
      end
      S_R2: begin
        val_nxt   = {rdata_r, lo_r};
        reg_we    = 1'b1;
        reg_widx  = 3'd6;
        reg_wdata = ptr_r + 16'd2;
        state_nxt = S_R3;
      end
      S_R3: begin
        rd_idx    = ir_r[2:0];
        reg_we    = 1'b1;
        reg_widx  = 3'd7;
        reg_wdata = reg_rd;
        state_nxt = S_R4;
      end
      S_R4: begin
        reg_we    = 1'b1;
        reg_widx  = ir_r[2:0];
        reg_wdata = val_r;
        state_nxt = S_DONE;
      end
      S_RST0: begin
        mem_addr  = MSC_CON_STATUS;
        state_nxt = S_RST1;
      end
      S_RST1: begin
        mem_we    = 1'b1;
        mem_addr  = MSC_CON_STATUS;
        mem_wdata = rdata_r | 8'h80;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (ea_set) begin
      if (word_acc && ea_val[0]) begin
        fault_req  = 1'b1;
        fault_code = ST_ODD;
      end else begin
        isreg_nxt = 1'b0;
        ea_nxt    = ea_val;
        state_nxt = cont_state;
      end
    end

    // a fault drops every side effect of the instruction
    if (fault_req) begin
      status_nxt = fault_code;
      restore    = 1'b1;
      reg_we     = 1'b0;
      mem_we     = 1'b0;
      halted_nxt = 1'b1;
      fn_nxt     = sfn_r;
      fz_nxt     = sfz_r;
      conv_nxt   = 1'b0;
      conc_nxt   = '0;
      state_nxt  = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr[AW-1:0]] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= '0;
      end
      regs_r[7] <= MSC_START_RESET;
    end else if (restore) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= saved_r[i];
      end
    end else if (reg_we) begin
      regs_r[reg_widx] <= reg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (snap) begin
      for (int i = 0; i < 8; i++) begin
        saved_r[i] <= regs_r[i];
      end
      sfn_r <= fn_r;
      sfz_r <= fz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      halted_r <= 1'b0;
      fn_r     <= 1'b0;
      fz_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      halted_r <= halted_nxt;
      fn_r     <= fn_nxt;
      fz_r     <= fz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ir_r     <= ir_nxt;
    cls_r    <= cls_nxt;
    phase_r  <= phase_nxt;
    isreg_r  <= isreg_nxt;
    ea_r     <= ea_nxt;
    lo_r     <= lo_nxt;
    val_r    <= val_nxt;
    src_r    <= src_nxt;
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    readv_r  <= readv_nxt;
    conv_r   <= conv_nxt;
    conc_r   <= conc_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);

  assign res.status        = status_r;
  assign res.read_value    = readv_r;
  assign res.pc_now        = regs_r[7];
  assign res.console_valid = conv_r;
  assign res.console_char  = conc_r;
  assign res.flag_n        = fn_r;
  assign res.flag_z        = fz_r;

endmodule

@@ src/minicomputer_subset_core.sv @@
// Sixteen-bit minicomputer core with a byte memory of MEM_BYTES entries.
// Input channel (in_valid/in_ready/in_data) carries one command word:
// load a memory byte, execute one instruction, read a register or restart.
// Every command returns exactly one result word on out_valid/out_ready
// with status, register value, pc, console byte and N/Z flags.
// Each memory byte is a separate access to the single-port main memory,
// which sets the instruction time.
// The start address register sits at byte address 0 of the psel/penable
// port (reset 512); write it only while the core is idle.
// After reset the core sweeps the main memory, clearing it and setting
// the console status byte, with in_ready low.
// A finished result waits in the output register while the core takes
// the next command; the core holds its following result until the
// output register frees.
module minicomputer_subset_core
  import msc_pkg::*;
#(
  parameter int MEM_BYTES = MSC_MEM_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  msc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output msc_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   start_r;
  logic          out_valid_r;
  msc_out_t      out_data_r;
  msc_eng_stat_t eng_stat;
  msc_out_t      eng_res;
  logic          take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, start_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= MSC_START_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      start_r <= pwdata[15:0];
    end
  end

  assign in_ready = eng_stat.idle;
  assign take     = eng_stat.done && (!out_valid_r || out_ready);

  msc_engine #(
    .MEM_BYTES(MEM_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid && in_ready),
    .cmd_in       (in_data),
    .start_address(start_r),
    .take         (take),
    .stat         (eng_stat),
    .res          (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= eng_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
